### rtl/msts_pkg.sv
// Shared constants and types for the multi-server task scheduler.
package msts_pkg;

    localparam int DEF_MAX_SERVERS = 16;
    localparam int DEF_TIME_BITS   = 48;

    localparam int ARRIVAL_BITS = 48;
    localparam int PROC_BITS    = 32;
    localparam int OUT_BITS     = 48;
    localparam int COUNT_BITS   = 5;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register index codes (byte address divided by four).
    localparam logic [0:0] REG_SERVER_COUNT = 1'b0;

    localparam logic [COUNT_BITS-1:0] SERVER_COUNT_RESET = COUNT_BITS'(1);

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic clear;
        logic wr_en;
    } cell_ctl_t;

endpackage

### rtl/msts_req_if.sv
// Task request channel: valid/ready handshake carrying one task word.
interface msts_req_if
    import msts_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    start_batch;
    logic [ARRIVAL_BITS-1:0] arrival_time;
    logic [PROC_BITS-1:0]    processing_time;

    modport source (
        output valid,
        output start_batch,
        output arrival_time,
        output processing_time,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_batch,
        input  arrival_time,
        input  processing_time,
        output ready
    );
endinterface

### rtl/msts_rsp_if.sv
// Result channel: valid/ready handshake carrying one schedule word.
interface msts_rsp_if
    import msts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] start_time;
    logic [OUT_BITS-1:0] finish_time;
    logic                saturated;

    modport source (
        output valid,
        output start_time,
        output finish_time,
        output saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  start_time,
        input  finish_time,
        input  saturated,
        output ready
    );
endinterface

### rtl/msts_cell.sv
// One server cell: holds a free time and folds it into the passing minimum.
module msts_cell
    import msts_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS,
    parameter int IDX_BITS  = 4,
    parameter int CELL_IDX  = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctl_t            ctl,
    input  logic [IDX_BITS-1:0]  wr_idx,
    input  logic [TIME_BITS-1:0] wr_data,
    input  logic [TIME_BITS-1:0] min_in,
    input  logic [IDX_BITS-1:0]  idx_in,
    output logic [TIME_BITS-1:0] min_out,
    output logic [IDX_BITS-1:0]  idx_out
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic [TIME_BITS-1:0] free_reg;
    logic [TIME_BITS-1:0] min_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic                 take;

    // Strict compare keeps the lower-numbered server on a tie.
    assign take = free_reg < min_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
        end
        else if (ctl.clear)
        begin
            free_reg <= '0;
        end
        else if (ctl.wr_en && (wr_idx == MY_IDX))
        begin
            free_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= take ? free_reg : min_in;
        idx_reg <= take ? MY_IDX : idx_in;
    end

    assign min_out = min_reg;
    assign idx_out = idx_reg;

endmodule

### rtl/multi_server_task_scheduler.sv
// Top level of the multi-server task scheduler: sequencer, cell row and APB register.
//
// Each task word passes through the sequencer states in order (a server_count of
// 0 counts as 1, any value above MAX_SERVERS as MAX_SERVERS): IDLE accepts it,
// LAUNCH starts a minimum search down the row of server cells, SEARCH lets the
// running minimum walk one cell per cycle across the servers in use, PICK picks
// the start time, and DONE forms the finish time, writes it back and loads the
// result register. A result waiting in the output register does not keep the
// next task from being accepted; it holds the block only when the next result
// is ready to be loaded. start_batch clears every server's free time in the
// accept cycle. Free times are cleared at reset, so no initialization pass runs.
module multi_server_task_scheduler
    import msts_pkg::*;
#(
    parameter int MAX_SERVERS = DEF_MAX_SERVERS,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    msts_req_if.sink                 req,
    msts_rsp_if.source               rsp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int IDX_BITS = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = ($clog2(MAX_SERVERS + 1) > COUNT_BITS) ?
                        $clog2(MAX_SERVERS + 1) : COUNT_BITS;
    localparam int AW = (ARRIVAL_BITS > TIME_BITS) ? ARRIVAL_BITS : TIME_BITS;
    localparam int SUM_BITS = ((TIME_BITS > PROC_BITS) ? TIME_BITS : PROC_BITS) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LAUNCH = 5'b00010,
        S_SEARCH = 5'b00100,
        S_PICK   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_BITS-1:0]     cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]   server_count_reg;
    logic [TIME_BITS-1:0]    arrival_reg;
    logic [PROC_BITS-1:0]    proc_reg;
    logic [TIME_BITS-1:0]    earliest_reg;
    logic [IDX_BITS-1:0]     best_reg;
    logic [TIME_BITS-1:0]    start_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0]    out_start_reg;
    logic [TIME_BITS-1:0]    out_finish_reg;
    logic                    out_sat_reg;

    logic                    accept;
    logic                    out_free;
    logic                    finish_load;
    logic [IDX_BITS-1:0]     last_idx;
    logic [CW-1:0]           count_ext;
    logic [AW-1:0]           arrival_ext;
    logic [TIME_BITS-1:0]    arrival_clamped;
    logic [SUM_BITS-1:0]     sum;
    logic                    sat;
    logic [TIME_BITS-1:0]    finish;
    logic                    cfg_write;
    cell_ctl_t               ctl;

    logic [TIME_BITS-1:0]    tok_min [MAX_SERVERS];
    logic [IDX_BITS-1:0]     tok_idx [MAX_SERVERS];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg <= SERVER_COUNT_RESET;
        end
        else if (cfg_write && (paddr[APB_ADDR_BITS-1:2] == REG_SERVER_COUNT))
        begin
            server_count_reg <= pwdata[COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        if (paddr[APB_ADDR_BITS-1:2] == REG_SERVER_COUNT)
        begin
            prdata = APB_DATA_BITS'(server_count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Index of the last server in use.
    always_comb
    begin
        count_ext = CW'(server_count_reg);
        if (count_ext == '0)
        begin
            last_idx = '0;
        end
        else if (count_ext > CW'(MAX_SERVERS))
        begin
            last_idx = IDX_BITS'(MAX_SERVERS - 1);
        end
        else
        begin
            last_idx = IDX_BITS'(count_ext - CW'(1));
        end
    end

    // ---------------- handshakes ----------------
    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign finish_load = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        arrival_ext = AW'(req.arrival_time);
        if (arrival_ext > AW'(TMAX))
        begin
            arrival_clamped = TMAX;
        end
        else
        begin
            arrival_clamped = TIME_BITS'(arrival_ext);
        end
    end

    // ---------------- finish time ----------------
    always_comb
    begin
        sum = SUM_BITS'(start_reg) + SUM_BITS'(proc_reg);
        sat = sum > SUM_BITS'(TMAX);
        finish = sat ? TMAX : TIME_BITS'(sum);
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SEARCH;
                cnt_next   = '0;
            end
            S_SEARCH:
            begin
                // The minimum over cells 0..k passes through the registers of cells 0 to k before it leaves cell k.
                if (cnt_reg == last_idx)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_BITS'(1);
                end
            end
            S_PICK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (finish_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arrival_reg <= arrival_clamped;
            proc_reg    <= req.processing_time;
        end
        if ((state_reg == S_SEARCH) && (cnt_reg == last_idx))
        begin
            earliest_reg <= tok_min[last_idx];
            best_reg     <= tok_idx[last_idx];
        end
        if (state_reg == S_PICK)
        begin
            start_reg <= (earliest_reg <= arrival_reg) ? arrival_reg : earliest_reg;
        end
        if (finish_load)
        begin
            out_start_reg  <= start_reg;
            out_finish_reg <= finish;
            out_sat_reg    <= sat;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.start_time  = OUT_BITS'(out_start_reg);
    assign rsp.finish_time = OUT_BITS'(out_finish_reg);
    assign rsp.saturated   = out_sat_reg;

    // ---------------- cell row ----------------
    assign ctl.clear = accept && req.start_batch;
    assign ctl.wr_en = finish_load;

    for (genvar i = 0; i < MAX_SERVERS; i++)
    begin : g_cell
        logic [TIME_BITS-1:0] min_in;
        logic [IDX_BITS-1:0]  idx_in;

        if (i == 0)
        begin : g_head
            // The row head is fed a fresh search every cycle.
            assign min_in = TMAX;
            assign idx_in = '0;
        end
        else
        begin : g_link
            assign min_in = tok_min[i-1];
            assign idx_in = tok_idx[i-1];
        end

        msts_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_BITS  (IDX_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .wr_idx  (best_reg),
            .wr_data (finish),
            .min_in  (min_in),
            .idx_in  (idx_in),
            .min_out (tok_min[i]),
            .idx_out (tok_idx[i])
        );
    end

    // ---------------- assertions ----------------
    a_best_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (best_reg <= last_idx))
        else $error("selected server lies outside the servers in use");

    a_start_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> ((start_reg >= arrival_reg) && (start_reg >= earliest_reg)))
        else $error("start time earlier than arrival or earliest free time");

    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_finish_reg >= out_start_reg))
        else $error("finish time precedes start time");

    a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> (out_finish_reg == TMAX))
        else $error("saturated result not clipped to the time range maximum");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        finish_load |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished task did not reach the output register");

endmodule
